// ===== hw/rtl/eegbp_pkg.sv =====
`timescale 1ns / 1ps

package eegbp_pkg;

   localparam logic [7:0] SYNC_BYTE       = 8'hAA;
   localparam logic [7:0] MAX_LEN         = 8'd170;
   localparam logic [7:0] LONG_CODE       = 8'h80;
   localparam logic [7:0] CODE_BATTERY    = 8'h01;
   localparam logic [7:0] CODE_POOR       = 8'h02;
   localparam logic [7:0] CODE_ATTENTION  = 8'h04;
   localparam logic [7:0] CODE_MEDITATION = 8'h05;
   localparam logic [7:0] CODE_BAND       = 8'h83;
   localparam logic [7:0] EXT_CODE_RESET  = 8'h55;

   localparam int BAND_COUNT = 8;
   localparam int BAND_W     = 24;
   localparam int BAND_BYTES = BAND_COUNT * BAND_W / 8;
   localparam int BAND_IDX_W = $clog2(BAND_COUNT);
   localparam int OFF_W      = $clog2(BAND_BYTES);
   localparam int POS_W      = 9;

   localparam logic [BAND_IDX_W-1:0] LAST_BAND = BAND_IDX_W'(BAND_COUNT - 1);

   typedef enum logic [3:0] {
      ST_SYNC1,
      ST_SYNC2,
      ST_LEN,
      ST_DATA,
      ST_CHECK,
      ST_WALK_START,
      ST_SKIP_RD,
      ST_SKIP_CHK,
      ST_SPAN_RD,
      ST_SPAN_GET,
      ST_VAL_RD,
      ST_VAL_GET,
      ST_ADVANCE,
      ST_WALK_END,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic len_load;
      logic frame_start;
      logic data_take;
      logic walk_start;
      logic pos_inc;
      logic code_load;
      logic span_load;
      logic span_one;
      logic val_take;
      logic off_inc;
      logic off_clear;
      logic pos_advance;
      logic emit_start;
      logic emit_next;
   } cmd_type;

   typedef struct packed {
      logic byte_is_sync;
      logic len_over;
      logic len_is_max;
      logic data_done;
      logic sum_ok;
      logic load_is_ext;
      logic code_long;
      logic code_is_band;
      logic walk_done;
      logic off_last;
      logic seen_bands;
      logic emit_last;
   } status_type;

endpackage

// ===== hw/rtl/eegbp_datapath.sv =====
`timescale 1ns / 1ps

module eegbp_datapath
   import eegbp_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [7:0]            rx_byte,
   input  logic                  csr_we,
   input  logic [7:0]            csr_data,
   output logic [BAND_IDX_W-1:0] band_index,
   output logic [BAND_W-1:0]     band_power,
   output logic [7:0]            attention,
   output logic [7:0]            meditation,
   output logic [7:0]            poor_signal,
   output logic                  has_poor_signal,
   output logic [7:0]            battery,
   output logic                  has_battery,
   output logic                  last
);

   localparam int AW    = $clog2(PAYLOAD_DEPTH);
   localparam int SR_W  = BAND_COUNT * BAND_W;

   logic [7:0]            ext_code_ff;
   logic [7:0]            len_ff;
   logic [7:0]            taken_ff;
   logic [7:0]            sum_ff;
   logic [7:0]            mem [PAYLOAD_DEPTH];
   logic [7:0]            rd_data_ff;
   logic                  rd_ok_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [OFF_W-1:0]      off_ff;
   logic [7:0]            code_ff;
   logic [7:0]            span_ff;
   logic [SR_W-1:0]       band_sr_ff;
   logic [7:0]            attention_ff;
   logic [7:0]            meditation_ff;
   logic [7:0]            poor_ff;
   logic                  has_poor_ff;
   logic [7:0]            battery_ff;
   logic                  has_battery_ff;
   logic                  seen_ff;
   logic [BAND_IDX_W-1:0] emit_idx_ff;

   logic [POS_W-1:0]      rd_addr;
   logic [POS_W-1:0]      len_ext;
   logic [7:0]            ld;

   assign len_ext = {1'b0, len_ff};
   assign rd_addr = pos_ff + POS_W'(off_ff);
   // reads at or past the payload end give zero
   assign ld      = rd_ok_ff ? rd_data_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_code_ff <= EXT_CODE_RESET;
      end else if (csr_we) begin
         ext_code_ff <= csr_data;
      end
   end

   // payload store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.data_take) begin
         mem[taken_ff[AW-1:0]] <= rx_byte;
      end
      rd_data_ff <= mem[rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff         <= '0;
         taken_ff       <= '0;
         sum_ff         <= '0;
         rd_ok_ff       <= 1'b0;
         pos_ff         <= '0;
         off_ff         <= '0;
         code_ff        <= '0;
         span_ff        <= '0;
         attention_ff   <= '0;
         meditation_ff  <= '0;
         poor_ff        <= '0;
         has_poor_ff    <= 1'b0;
         battery_ff     <= '0;
         has_battery_ff <= 1'b0;
         seen_ff        <= 1'b0;
         emit_idx_ff    <= '0;
      end else begin
         rd_ok_ff <= rd_addr < len_ext;
         if (cmd.len_load) begin
            len_ff <= rx_byte;
         end
         if (cmd.frame_start) begin
            taken_ff <= '0;
            sum_ff   <= '0;
         end
         if (cmd.data_take) begin
            taken_ff <= taken_ff + 8'd1;
            sum_ff   <= sum_ff + rx_byte;
         end
         if (cmd.walk_start) begin
            pos_ff         <= '0;
            attention_ff   <= '0;
            meditation_ff  <= '0;
            poor_ff        <= '0;
            has_poor_ff    <= 1'b0;
            battery_ff     <= '0;
            has_battery_ff <= 1'b0;
            seen_ff        <= 1'b0;
         end
         if (cmd.pos_inc) begin
            pos_ff <= pos_ff + POS_W'(1);
         end
         if (cmd.pos_advance) begin
            pos_ff <= pos_ff + POS_W'(span_ff);
         end
         if (cmd.code_load) begin
            code_ff <= ld;
         end
         if (cmd.span_load) begin
            span_ff <= ld;
         end
         if (cmd.span_one) begin
            span_ff <= 8'd1;
         end
         if (cmd.off_inc) begin
            off_ff <= off_ff + OFF_W'(1);
         end
         if (cmd.off_clear) begin
            off_ff <= '0;
         end
         if (cmd.val_take) begin
            case (code_ff)
               CODE_BATTERY: begin
                  battery_ff     <= ld;
                  has_battery_ff <= 1'b1;
               end
               CODE_POOR: begin
                  poor_ff     <= ld;
                  has_poor_ff <= 1'b1;
               end
               CODE_ATTENTION:  attention_ff  <= ld;
               CODE_MEDITATION: meditation_ff <= ld;
               CODE_BAND:       seen_ff       <= 1'b1;
               default: ;
            endcase
         end
         if (cmd.emit_start) begin
            emit_idx_ff <= '0;
         end
         if (cmd.emit_next) begin
            emit_idx_ff <= emit_idx_ff + BAND_IDX_W'(1);
         end
      end
   end

   // band bytes shift in big-endian, results shift out from the top
   always_ff @(posedge clock) begin
      if (cmd.val_take && code_ff == CODE_BAND) begin
         band_sr_ff <= {band_sr_ff[SR_W-9:0], ld};
      end else if (cmd.emit_next) begin
         band_sr_ff <= {band_sr_ff[SR_W-BAND_W-1:0], {BAND_W{1'b0}}};
      end
   end

   always_comb begin
      status.byte_is_sync = rx_byte == SYNC_BYTE;
      status.len_over     = rx_byte > MAX_LEN;
      status.len_is_max   = rx_byte == MAX_LEN;
      status.data_done    = ({1'b0, taken_ff} + POS_W'(1)) >= len_ext;
      status.sum_ok       = rx_byte == ~sum_ff;
      status.load_is_ext  = ld == ext_code_ff;
      status.code_long    = code_ff >= LONG_CODE;
      status.code_is_band = code_ff == CODE_BAND;
      status.walk_done    = pos_ff >= len_ext;
      status.off_last     = off_ff == OFF_W'(BAND_BYTES - 1);
      status.seen_bands   = seen_ff;
      status.emit_last    = emit_idx_ff == LAST_BAND;
   end

   assign band_index      = emit_idx_ff;
   assign band_power      = band_sr_ff[SR_W-1 -: BAND_W];
   assign attention       = attention_ff;
   assign meditation      = meditation_ff;
   assign poor_signal     = poor_ff;
   assign has_poor_signal = has_poor_ff;
   assign battery         = battery_ff;
   assign has_battery     = has_battery_ff;
   assign last            = emit_idx_ff == LAST_BAND;

endmodule

// ===== hw/rtl/eegbp_ctrl.sv =====
`timescale 1ns / 1ps

module eegbp_ctrl
   import eegbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC1;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_SYNC1: begin
            req_stall = 1'b0;
            if (req_valid && status.byte_is_sync) begin
               state_in = ST_SYNC2;
            end
         end
         ST_SYNC2: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = status.byte_is_sync ? ST_LEN : ST_SYNC1;
            end
         end
         ST_LEN: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.len_load = 1'b1;
               if (status.len_over) begin
                  state_in = ST_SYNC1;
               end else if (!status.len_is_max) begin
                  // a length of exactly 170 is one more sync byte
                  cmd.frame_start = 1'b1;
                  state_in        = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.data_take = 1'b1;
               if (status.data_done) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = status.sum_ok ? ST_WALK_START : ST_SYNC1;
            end
         end
         ST_WALK_START: begin
            cmd.walk_start = 1'b1;
            state_in       = ST_SKIP_RD;
         end
         ST_SKIP_RD: begin
            state_in = status.walk_done ? ST_WALK_END : ST_SKIP_CHK;
         end
         ST_SKIP_CHK: begin
            cmd.pos_inc = 1'b1;
            if (status.load_is_ext) begin
               state_in = ST_SKIP_RD;
            end else begin
               cmd.code_load = 1'b1;
               state_in      = ST_SPAN_RD;
            end
         end
         ST_SPAN_RD: begin
            if (status.code_long) begin
               state_in = ST_SPAN_GET;
            end else begin
               cmd.span_one = 1'b1;
               state_in     = ST_VAL_RD;
            end
         end
         ST_SPAN_GET: begin
            cmd.span_load = 1'b1;
            cmd.pos_inc   = 1'b1;
            state_in      = ST_VAL_RD;
         end
         ST_VAL_RD: begin
            state_in = ST_VAL_GET;
         end
         ST_VAL_GET: begin
            cmd.val_take = 1'b1;
            if (status.code_is_band && !status.off_last) begin
               cmd.off_inc = 1'b1;
               state_in    = ST_VAL_RD;
            end else begin
               cmd.off_clear = 1'b1;
               state_in      = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.pos_advance = 1'b1;
            state_in        = ST_SKIP_RD;
         end
         ST_WALK_END: begin
            if (status.seen_bands) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               state_in = ST_SYNC1;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.emit_next = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_SYNC1;
               end
            end
         end
         default: begin
            state_in = ST_SYNC1;
         end
      endcase
   end

endmodule

// ===== hw/rtl/eeg_band_power_packet_parser.sv =====
`timescale 1ns / 1ps

// Frame parser for an EEG headset byte stream. While framing, one byte is taken
// per cycle (sync, sync, length, payload, checksum). After a good checksum the
// input stalls while the stored payload is walked through the single read port
// of the payload memory, each byte read setting the address and then taking the
// registered data. Extended-code bytes are skipped; each row reads its code, a
// length byte for a long code and its value bytes. ST_WALK_START begins the walk
// and ST_WALK_END ends it. A frame with a band row then gives eight result beats,
// one per cycle while the output is not stalled, and only after the eighth is
// the next byte taken. The payload memory needs no clearing pass after reset.
module eeg_band_power_packet_parser
   import eegbp_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_band_index,
   output logic [23:0] rsp_band_power,
   output logic [7:0]  rsp_attention,
   output logic [7:0]  rsp_meditation,
   output logic [7:0]  rsp_poor_signal,
   output logic        rsp_has_poor_signal,
   output logic [7:0]  rsp_battery,
   output logic        rsp_has_battery,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_extended_code_value
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   eegbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   eegbp_datapath #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rx_byte         (req_rx_byte),
      .csr_we          (csr_valid && csr_ready),
      .csr_data        (csr_extended_code_value),
      .band_index      (rsp_band_index),
      .band_power      (rsp_band_power),
      .attention       (rsp_attention),
      .meditation      (rsp_meditation),
      .poor_signal     (rsp_poor_signal),
      .has_poor_signal (rsp_has_poor_signal),
      .battery         (rsp_battery),
      .has_battery     (rsp_has_battery),
      .last            (rsp_last)
   );

   // no byte is taken while results are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while results pending");

   // the last beat ends the burst
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !rsp_valid)
      else $error("results continue after last beat");

   // bands come out in order without gaps
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=>
         (rsp_valid && rsp_band_index == $past(rsp_band_index) + 3'd1))
      else $error("band sequence broken");

   // a burst always starts at band zero
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_band_index == 3'd0)
      else $error("burst does not start at band zero");

endmodule
